FILE: hw/rtl/pdfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfr_pkg: shared types and constants for the data frame receiver
// Item structs, parser phase and status codes, frame layout constants.
// ----------------------------------------------------------------------------
package pdfr_pkg;

  localparam logic [7:0]  HdrByte        = 8'h79;
  localparam logic [16:0] FixedDataLen   = 17'd10;  // data ctrl + addr + user length
  localparam logic [16:0] BodyOverhead   = 17'd4;   // header offset of the data field
  localparam logic [15:0] MaxUserLenRst  = 16'd256;
  localparam int unsigned AddrBytes      = 6;

  // Byte positions inside a frame, counted from the header byte at zero
  localparam logic [16:0] PosLenLo   = 17'd1;
  localparam logic [16:0] PosLenHi   = 17'd2;
  localparam logic [16:0] PosAddr0   = 17'd7;
  localparam logic [16:0] PosUlenLo  = 17'd13;
  localparam logic [16:0] PosUlenHi  = 17'd14;
  localparam logic [16:0] PosUser0   = 17'd15;
  localparam logic [16:0] PosBodyMin = 17'd4;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_CSUM = 2'd2,
    PH_CXOR = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_HDR = 3'd1,
    ST_CHECK   = 3'd2,
    ST_LENGTH  = 3'd3,
    ST_SIZE    = 3'd4
  } status_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    status_e     status;
    logic [47:0] origin_addr;
    logic [15:0] user_len;
  } out_item_t;

endpackage

FILE: hw/rtl/pdfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfr_parser: frame parser state and per-byte update
// Holds the frame state; on each step consumes one byte and forms at most
// one result.
// ----------------------------------------------------------------------------
module pdfr_parser
  import pdfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  in_item_t    item_i,
  input  logic [15:0] max_user_len_i,
  output logic        res_valid_o,
  output out_item_t   res_o
);

  phase_e      phase_q, phase_d;
  logic [16:0] byte_pos_q, byte_pos_d;
  logic [15:0] data_len_q, data_len_d;
  logic [7:0]  run_sum_q, run_sum_d;
  logic [7:0]  run_xor_q, run_xor_d;
  logic [7:0]  got_sum_q, got_sum_d;
  logic [47:0] origin_addr_q, origin_addr_d;
  logic [15:0] user_len_q, user_len_d;

  logic [7:0]  b;
  logic        start;
  logic        length_ok;
  logic        size_ok;
  logic        body_end;

  assign b         = item_i.rx_byte;
  assign start     = item_i.frame_start;
  assign length_ok = ({1'b0, data_len_q} >= FixedDataLen) &&
                     ((FixedDataLen + {1'b0, user_len_q}) == {1'b0, data_len_q});
  assign size_ok   = user_len_q <= max_user_len_i;
  assign body_end  = (byte_pos_q >= PosBodyMin) &&
                     (byte_pos_q == ({1'b0, data_len_q} + BodyOverhead));

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (start) begin
      phase_d = (b == HdrByte) ? PH_BODY : PH_IDLE;
    end else begin
      unique case (phase_q)
        PH_IDLE: phase_d = PH_IDLE;
        PH_BODY: phase_d = body_end ? PH_CSUM : PH_BODY;
        PH_CSUM: phase_d = PH_CXOR;
        PH_CXOR: phase_d = PH_IDLE;
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    byte_pos_d    = byte_pos_q;
    data_len_d    = data_len_q;
    run_sum_d     = run_sum_q;
    run_xor_d     = run_xor_q;
    got_sum_d     = got_sum_q;
    origin_addr_d = origin_addr_q;
    user_len_d    = user_len_q;
    res_valid_o   = 1'b0;
    res_o         = '{kind: KIND_STATUS, data_byte: 8'h00, status: ST_OK,
                      origin_addr: 48'h0, user_len: 16'h0};

    if (start) begin
      byte_pos_d    = 17'd1;
      data_len_d    = '0;
      run_sum_d     = '0;
      run_xor_d     = '0;
      got_sum_d     = '0;
      origin_addr_d = '0;
      user_len_d    = '0;
      if (b != HdrByte) begin
        res_valid_o  = 1'b1;
        res_o.status = ST_BAD_HDR;
      end
    end else begin
      unique case (phase_q)
        PH_BODY: begin
          run_sum_d  = run_sum_q + b;
          run_xor_d  = run_xor_q ^ b;
          byte_pos_d = byte_pos_q + 17'd1;
          if (byte_pos_q == PosLenLo) begin
            data_len_d[7:0] = b;
          end else if (byte_pos_q == PosLenHi) begin
            data_len_d[15:8] = b;
          end else if (byte_pos_q == PosUlenLo) begin
            user_len_d[7:0] = b;
          end else if (byte_pos_q == PosUlenHi) begin
            user_len_d[15:8] = b;
          end else if (byte_pos_q >= PosUser0) begin
            if (length_ok && size_ok) begin
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_DATA;
              res_o.data_byte   = b;
              res_o.origin_addr = origin_addr_q;
              res_o.user_len    = user_len_q;
            end
          end
          // Address bytes land in their own lane
          for (int i = 0; i < AddrBytes; i++) begin
            if (byte_pos_q == PosAddr0 + 17'(i)) begin
              origin_addr_d[8*i +: 8] = b;
            end
          end
        end
        PH_CSUM: got_sum_d = b;
        PH_CXOR: begin
          res_valid_o = 1'b1;
          if (got_sum_q != run_sum_q || b != run_xor_q) begin
            res_o.status = ST_CHECK;
          end else if (!length_ok) begin
            res_o.status      = ST_LENGTH;
            res_o.origin_addr = origin_addr_q;
            res_o.user_len    = user_len_q;
          end else if (!size_ok) begin
            res_o.status      = ST_SIZE;
            res_o.origin_addr = origin_addr_q;
          end else begin
            res_o.status      = ST_OK;
            res_o.origin_addr = origin_addr_q;
            res_o.user_len    = user_len_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      byte_pos_q    <= '0;
      data_len_q    <= '0;
      run_sum_q     <= '0;
      run_xor_q     <= '0;
      got_sum_q     <= '0;
      origin_addr_q <= '0;
      user_len_q    <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      byte_pos_q    <= byte_pos_d;
      data_len_q    <= data_len_d;
      run_sum_q     <= run_sum_d;
      run_xor_q     <= run_xor_d;
      got_sum_q     <= got_sum_d;
      origin_addr_q <= origin_addr_d;
      user_len_q    <= user_len_d;
    end
  end

endmodule

FILE: hw/rtl/plc_data_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_data_frame_receiver_top: length-prefixed frame receiver
// Parses 0x79-headed frames byte by byte, checks sum and XOR, passes user
// bytes and ends each frame with one status item.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                               | Dir | Carries
//  ---------+---------------------------------------+-----+------------------------
//  in       | in_valid_i, in_ready_o, in_item_i     | in  | one received byte
//  out      | out_valid_o, out_ready_i, out_item_o  | out | user byte or status item
//  cfg      | cfg_we_i, cfg_wdata_i                 | in  | max_user_len write
//
//  Each byte passes through the input register, then the parser step that
//  writes the result register. One item per cycle is sustained while the
//  output is not stalled; the parser state update loops on its registers.
//  Reset clears the parser to idle and max_user_len to 256.
//  A stalled output holds its item and stops the parser step; the input
//  register still fills, and the input side stalls only when both are full.
// ----------------------------------------------------------------------------
module plc_data_frame_receiver_top
  import pdfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] max_user_len_q;

  logic        in_v_q, in_v_d;
  in_item_t    in_item_q;
  logic        out_v_q, out_v_d;
  out_item_t   out_item_q;

  logic        out_free;
  logic        step;
  logic        res_valid;
  out_item_t   res;

  // Advance the parser only when the result register can take its output
  assign out_free   = !out_v_q || out_ready_i;
  assign step       = in_v_q && out_free;
  assign in_ready_o = !in_v_q || step;

  assign in_v_d  = in_ready_o ? in_valid_i : in_v_q;
  assign out_v_d = out_free ? (step && res_valid) : out_v_q;

  pdfr_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (in_item_q),
    .max_user_len_i (max_user_len_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // Configuration register, read live by the parser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_user_len_q <= MaxUserLenRst;
    end else if (cfg_we_i) begin
      max_user_len_q <= cfg_wdata_i;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload registers: capture on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (step && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_item_q;

endmodule
